// File: rtl/core/cfsa_pkg.sv
// Shared constants, types and helper functions of the circular free slot allocator.
package cfsa_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int SLOT_W    = $clog2(MAX_SLOTS);
  localparam int CNT_W     = SLOT_W + 1;
  localparam int WORD_W    = 64;
  localparam int WORD_BITS = $clog2(WORD_W);
  localparam int ROWS      = MAX_SLOTS / WORD_W;
  localparam int ROW_W     = SLOT_W - WORD_BITS;
  localparam int SCAN_W    = ROW_W + 1;

  localparam int TDATA_W   = ((SLOT_W + 7) / 8) * 8;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 3;

  localparam logic [CNT_W-1:0] SLOT_COUNT_RESET = CNT_W'(MAX_SLOTS);

  localparam logic MODE_ALLOC   = 1'b0;
  localparam logic MODE_RELEASE = 1'b1;

  localparam logic REG_SLOT_COUNT = 1'b0;

  typedef logic [ROW_W-1:0]  row_t;
  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    logic  rd_en;
    row_t  rd_addr;
    logic  wr_en;
    row_t  wr_addr;
    word_t wr_data;
  } map_req_t;

  // Bits of one row whose slot index lies below the active slot count.
  function automatic word_t row_limit_mask(input row_t row, input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] diff;
    word_t            mask;
    base = CNT_W'({row, {WORD_BITS{1'b0}}});
    diff = n - base;
    if (n <= base) begin
      mask = '0;
    end else if (diff >= CNT_W'(WORD_W)) begin
      mask = '1;
    end else begin
      mask = ~({WORD_W{1'b1}} << diff[WORD_BITS-1:0]);
    end
    return mask;
  endfunction

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [WORD_BITS-1:0] lowest_set(input word_t v);
    logic [WORD_BITS-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = WORD_BITS'(i);
      end
    end
    return idx;
  endfunction

endpackage

// File: rtl/core/cfsa_map.sv
// Occupancy map memory, one row of slot bits per word, with per-row valid bits.
module cfsa_map (
  input  logic                           clk,
  input  logic                           rst_n,
  input  cfsa_pkg::map_req_t             req,
  output logic [cfsa_pkg::WORD_W-1:0]    rd_data
);
  import cfsa_pkg::*;

  word_t            mem [ROWS];
  logic [ROWS-1:0]  row_valid_r;
  word_t            rd_word_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_word_r <= mem[req.rd_addr];
    end
  end

  // A row never written since reset reads as all free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (req.wr_en) begin
        row_valid_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= row_valid_r[req.rd_addr];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_word_r : '0;

endmodule

// File: rtl/core/circular_free_slot_allocator.sv
// An allocate runs through ST_SCAN and ST_DONE into the output register; a stalled out holds it in ST_DONE.
// The search reads one 64-slot row of the occupancy memory per cycle, at most 17 reads.
// A release in range reads its row and then clears the slot bit, one out of range is dropped; neither gives a result.
// A new request is accepted once the previous one has finished its work.
// Reset is synchronous and active low: all slots become free at once and slot_count is 1024.
// The result register holds a finished result while the next request is accepted.
module circular_free_slot_allocator (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [cfsa_pkg::APB_AW-1:0]    cfg_paddr,
  input  logic [cfsa_pkg::APB_DW-1:0]    cfg_pwdata,
  output logic [cfsa_pkg::APB_DW-1:0]    cfg_prdata,
  output logic                           cfg_pready,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [cfsa_pkg::TDATA_W-1:0]   in_tdata,   // [9:0] slot
  input  logic [0:0]                     in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [cfsa_pkg::TDATA_W-1:0]   out_tdata,  // [9:0] granted_slot
  output logic [0:0]                     out_tuser   // [0] full_res
);
  import cfsa_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_REL  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     slot_count_r;
  logic [CNT_W-1:0]     eff_n;
  logic [SCAN_W-1:0]    k_r, k_nxt;
  row_t                 hint_row_r, hint_row_nxt;
  logic [WORD_BITS-1:0] off_r, off_nxt;
  logic [SLOT_W-1:0]    res_slot_r, res_slot_nxt;
  logic                 res_full_r, res_full_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [SLOT_W-1:0]    out_slot_r, out_slot_nxt;
  logic                 out_full_r, out_full_nxt;

  map_req_t             map_req;
  word_t                rd_data;
  row_t                 cur_row;
  word_t                pos_mask;
  word_t                cand;
  logic                 found;
  logic [WORD_BITS-1:0] pick;
  logic                 in_acc;
  logic [SLOT_W-1:0]    in_slot;
  logic                 cfg_wr;

  cfsa_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (map_req),
    .rd_data (rd_data)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[APB_AW-1] == REG_SLOT_COUNT) ?
                      APB_DW'(slot_count_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= SLOT_COUNT_RESET;
    end else if (cfg_wr && cfg_paddr[APB_AW-1] == REG_SLOT_COUNT) begin
      slot_count_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    if (slot_count_r == '0) begin
      eff_n = CNT_W'(1);
    end else if (slot_count_r > CNT_W'(MAX_SLOTS)) begin
      eff_n = CNT_W'(MAX_SLOTS);
    end else begin
      eff_n = slot_count_r;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_slot   = in_tdata[SLOT_W-1:0];

  assign cur_row = hint_row_r + k_r[ROW_W-1:0];

  // The first row is searched from the hint upward, the final pass over it below the hint.
  always_comb begin
    if (k_r == '0) begin
      pos_mask = {WORD_W{1'b1}} << off_r;
    end else if (k_r == SCAN_W'(ROWS)) begin
      pos_mask = ~({WORD_W{1'b1}} << off_r);
    end else begin
      pos_mask = '1;
    end
  end

  assign cand  = ~rd_data & pos_mask & row_limit_mask(cur_row, eff_n);
  assign found = |cand;
  assign pick  = lowest_set(cand);

  always_comb begin
    state_nxt    = state_r;
    k_nxt        = k_r;
    hint_row_nxt = hint_row_r;
    off_nxt      = off_r;
    res_slot_nxt = res_slot_r;
    res_full_nxt = res_full_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_slot_nxt = out_slot_r;
    out_full_nxt = out_full_r;
    map_req      = '0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          hint_row_nxt = in_slot[SLOT_W-1:WORD_BITS];
          off_nxt      = in_slot[WORD_BITS-1:0];
          k_nxt        = '0;
          if (in_tuser[0] == MODE_ALLOC) begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = in_slot[SLOT_W-1:WORD_BITS];
            state_nxt       = ST_SCAN;
          end else if (CNT_W'(in_slot) < eff_n) begin
            map_req.rd_en   = 1'b1;
            map_req.rd_addr = in_slot[SLOT_W-1:WORD_BITS];
            state_nxt       = ST_REL;
          end
        end
      end
      ST_SCAN: begin
        if (found) begin
          map_req.wr_en   = 1'b1;
          map_req.wr_addr = cur_row;
          map_req.wr_data = rd_data | (WORD_W'(1) << pick);
          res_slot_nxt    = {cur_row, pick};
          res_full_nxt    = 1'b0;
          state_nxt       = ST_DONE;
        end else if (k_r == SCAN_W'(ROWS)) begin
          res_slot_nxt = '0;
          res_full_nxt = 1'b1;
          state_nxt    = ST_DONE;
        end else begin
          k_nxt           = k_r + SCAN_W'(1);
          map_req.rd_en   = 1'b1;
          map_req.rd_addr = hint_row_r + k_nxt[ROW_W-1:0];
        end
      end
      ST_REL: begin
        map_req.wr_en   = 1'b1;
        map_req.wr_addr = hint_row_r;
        map_req.wr_data = rd_data & ~(WORD_W'(1) << off_r);
        state_nxt       = ST_IDLE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = res_slot_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hint_row_r <= hint_row_nxt;
    off_r      <= off_nxt;
    res_slot_r <= res_slot_nxt;
    res_full_r <= res_full_nxt;
    out_slot_r <= out_slot_nxt;
    out_full_r <= out_full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_slot_r);
  assign out_tuser  = out_full_r;

endmodule

// File: rtl/core/cfsa_chk.sv
// Port-level checker for the circular free slot allocator and its bind statement.
module cfsa_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           cfg_pready,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [0:0]                     in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [cfsa_pkg::TDATA_W-1:0]   out_tdata,
  input logic [0:0]                     out_tuser
);
  import cfsa_pkg::*;

  // A full report never carries a slot number.
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[SLOT_W-1:0] == '0)
    else $error("full result carries a nonzero slot");

  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // An accepted allocate request keeps the block busy in the next cycle.
  a_alloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] == MODE_ALLOC |=> !in_tready)
    else $error("allocate request did not occupy the block");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_pready)
    else $error("configuration port not ready");

endmodule

bind circular_free_slot_allocator cfsa_chk u_cfsa_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .cfg_pready (cfg_pready),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// File: dv/tb.sv
// Self-checking testbench for the circular free slot allocator.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cfsa_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_TIME  = 24;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 150;
  localparam logic [CNT_W-1:0] PHASE_COUNTS [PHASES] = '{
    11'd2047, 11'd1, 11'd0, 11'd2, 11'd64, 11'd65, 11'd1000, 11'd130
  };

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              full_res;
  } grant_t;

  logic                clk         = 1'b0;
  logic                rst_n       = 1'b0;
  logic                cfg_psel    = 1'b0;
  logic                cfg_penable = 1'b0;
  logic                cfg_pwrite  = 1'b0;
  logic [APB_AW-1:0]   cfg_paddr   = '0;
  logic [APB_DW-1:0]   cfg_pwdata  = '0;
  logic [APB_DW-1:0]   cfg_prdata;
  logic                cfg_pready;
  logic                in_tvalid   = 1'b0;
  logic                in_tready;
  logic [TDATA_W-1:0]  in_tdata    = '0;
  logic [0:0]          in_tuser    = '0;
  logic                out_tvalid;
  logic                out_tready  = 1'b0;
  logic [TDATA_W-1:0]  out_tdata;
  logic [0:0]          out_tuser;

  bit               occupied [MAX_SLOTS];
  logic [CNT_W-1:0] slot_limit = SLOT_COUNT_RESET;
  grant_t           grant_q [$];
  grant_t           want;
  int               mismatches      = 0;
  int               cycles          = 0;
  int               hold_off_cycles = 0;
  bit               tx_idling       = 1'b1;
  bit               rx_idling       = 1'b1;

  circular_free_slot_allocator DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),   // [9:0] slot
    .in_tuser    (in_tuser),   // [0] mode
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),  // [9:0] granted_slot
    .out_tuser   (out_tuser)   // [0] full_res
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("circular_free_slot_allocator verification failed");
      $finish;
    end
  end

  function automatic int active_slots();
    if (slot_limit == '0) return 1;
    if (slot_limit > CNT_W'(MAX_SLOTS)) return MAX_SLOTS;
    return int'(slot_limit);
  endfunction

  // Applies one accepted request to the occupancy map and queues the grant that an allocate yields.
  function automatic void predict_request(input logic mode, input logic [SLOT_W-1:0] slot);
    int     n;
    int     pick;
    int     lim;
    grant_t g;
    n    = active_slots();
    pick = -1;
    if (mode == MODE_RELEASE) begin
      if (int'(slot) < n) occupied[slot] = 1'b0;
      return;
    end
    for (int i = int'(slot); i < n && pick < 0; i++) begin
      if (!occupied[i]) pick = i;
    end
    lim = (int'(slot) < n) ? int'(slot) : n;
    for (int i = 0; i < lim && pick < 0; i++) begin
      if (!occupied[i]) pick = i;
    end
    if (pick >= 0) begin
      occupied[pick]  = 1'b1;
      g.granted_slot  = SLOT_W'(pick);
      g.full_res      = 1'b0;
    end else begin
      g.granted_slot  = '0;
      g.full_res      = 1'b1;
    end
    grant_q.push_back(g);
  endfunction

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_request(in_tuser[0], in_tdata[SLOT_W-1:0]);
      if (out_tvalid && out_tready) begin
        if (grant_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got slot %0d full %0b",
                   $time, out_tdata, out_tuser[0]);
        end else begin
          want = grant_q.pop_front();
          if (out_tdata !== TDATA_W'(want.granted_slot)) begin
            mismatches++;
            $display("%0t: granted_slot expected %0d, got %0d",
                     $time, want.granted_slot, out_tdata);
          end
          if (out_tuser[0] !== want.full_res) begin
            mismatches++;
            $display("%0t: full_res expected %0b, got %0b", $time, want.full_res, out_tuser[0]);
          end
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin : result_sink
    int stall;
    forever begin
      @(posedge clk);
      stall = rx_idling ? pick_gap() : 0;
      if (hold_off_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (hold_off_cycles) @(posedge clk);
        hold_off_cycles = 0;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  task automatic send_request(input logic mode, input logic [SLOT_W-1:0] slot);
    int gap;
    gap = tx_idling ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= TDATA_W'(slot);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (grant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TIME) @(posedge clk);
  endtask

  task automatic write_slot_count(input logic [CNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= APB_AW'(int'(REG_SLOT_COUNT) * 4);
    cfg_pwdata  <= APB_DW'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    slot_limit = value;
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== APB_DW'(value)) begin
      mismatches++;
      $display("%0t: slot_count read expected %0d, got %0d", $time, value, cfg_prdata);
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic test_hint_wrap();
    send_request(MODE_ALLOC, 10'd0);
    send_request(MODE_ALLOC, 10'd1023);
    send_request(MODE_ALLOC, 10'd1023);
    send_request(MODE_ALLOC, 10'd512);
    send_request(MODE_RELEASE, 10'd1023);
    send_request(MODE_RELEASE, 10'd1023);
    send_request(MODE_ALLOC, 10'd1023);
    send_request(MODE_RELEASE, 10'd5);
    send_request(MODE_RELEASE, 10'd0);
    send_request(MODE_ALLOC, 10'd0);
  endtask

  task automatic test_count_limits();
    wait_idle();
    write_slot_count(11'd0);
    send_request(MODE_ALLOC, 10'd0);
    send_request(MODE_ALLOC, 10'd777);
    send_request(MODE_RELEASE, 10'd600);
    send_request(MODE_RELEASE, 10'd0);
    send_request(MODE_ALLOC, 10'd777);
    wait_idle();
    write_slot_count(11'd2);
    send_request(MODE_ALLOC, 10'd1);
    send_request(MODE_ALLOC, 10'd1);
    send_request(MODE_RELEASE, 10'd1);
    wait_idle();
    write_slot_count(11'd2047);
    send_request(MODE_ALLOC, 10'd1023);
    send_request(MODE_ALLOC, 10'd513);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] count;
    int               n;
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      count = (p == PHASES - 1) ? CNT_W'($urandom_range(3, 200)) : PHASE_COUNTS[p];
      write_slot_count(count);
      n         = active_slots();
      tx_idling = (p % 3 != 2);
      rx_idling = (p % 4 != 3);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 99) < 55) begin
          send_request(MODE_ALLOC, ($urandom_range(0, 4) == 0) ?
                       SLOT_W'($urandom_range(0, 1023)) : SLOT_W'($urandom_range(0, n - 1)));
        end else begin
          send_request(MODE_RELEASE, ($urandom_range(0, 6) == 0) ?
                       SLOT_W'($urandom_range(0, 1023)) : SLOT_W'($urandom_range(0, n - 1)));
        end
      end
    end
  endtask

  task automatic test_backpressure();
    wait_idle();
    write_slot_count(11'd64);
    tx_idling       = 1'b0;
    hold_off_cycles = 300;
    for (int k = 0; k < 40; k++) begin
      send_request(MODE_ALLOC, SLOT_W'($urandom_range(0, 1023)));
    end
    tx_idling = 1'b1;
    rx_idling = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_hint_wrap();
    test_count_limits();
    test_random_traffic();
    test_backpressure();
    wait_idle();
    if (mismatches == 0 && grant_q.size() == 0) begin
      $display("circular_free_slot_allocator verification clean");
    end else begin
      $display("circular_free_slot_allocator verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/cfsa_pkg.sv
rtl/core/cfsa_map.sv
rtl/core/circular_free_slot_allocator.sv
rtl/core/cfsa_chk.sv
dv/tb.sv
